// ===== rtl/banded_priority_queue_macros.svh =====
// Assertion macros for the banded priority queue.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef BANDED_PRIORITY_QUEUE_MACROS_SVH
`define BANDED_PRIORITY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpq_pkg.sv =====
// Shared types, constants and the class function of the banded priority queue.
// No dependencies.
package bpq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam int VAL_W = 7;
  localparam int POS_W = 4;

  // operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // classes
  localparam logic [1:0] CLS_URGENT = 2'd0;
  localparam logic [1:0] CLS_MIDDLE = 2'd1;
  localparam logic [1:0] CLS_NORMAL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_URGENT_BELOW = 2'd0;
  localparam logic [1:0] REG_URGENT_ABOVE = 2'd1;
  localparam logic [1:0] REG_MIDDLE_BELOW = 2'd2;
  localparam logic [1:0] REG_MIDDLE_ABOVE = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] taken_value;
    logic [1:0]       taken_class;
    logic [CNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] urgent_below;
    logic [VAL_W-1:0] urgent_above;
    logic [VAL_W-1:0] middle_below;
    logic [VAL_W-1:0] middle_above;
  } band_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             wr_en;
    logic [1:0]       kind;
    logic [VAL_W-1:0] value;
    logic [1:0]       new_cls;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
    band_t            bands;
  } cell_ctl_t;

  function automatic logic [1:0] class_of(logic [VAL_W-1:0] v, band_t b);
    logic [1:0] c;
    if (v < b.urgent_below || v > b.urgent_above) begin
      c = CLS_URGENT;
    end else if (v < b.middle_below || v > b.middle_above) begin
      c = CLS_MIDDLE;
    end else begin
      c = CLS_NORMAL;
    end
    return c;
  endfunction

endpackage

// ===== rtl/bpq_cell.sv =====
// One slot of the queue: holds an entry and shifts it toward either neighbor.
// Depends on bpq_pkg.
module bpq_cell (
  input  logic                       clk,
  input  bpq_pkg::cell_ctl_t         ctl,
  input  logic [bpq_pkg::IDX_W-1:0]  idx,
  input  logic [bpq_pkg::VAL_W-1:0]  prev_val,
  input  logic [bpq_pkg::VAL_W-1:0]  next_val,
  input  logic                       found_in,
  output logic                       found_out,
  input  logic [bpq_pkg::VAL_W-1:0]  carry_in,
  output logic [bpq_pkg::VAL_W-1:0]  carry_out,
  output logic [bpq_pkg::VAL_W-1:0]  val
);

  logic [bpq_pkg::VAL_W-1:0] val_r;
  logic [bpq_pkg::VAL_W-1:0] val_nxt;
  logic                      past_tail;
  logic                      greater;
  logic                      at_pos;
  logic                      from_pos;

  assign past_tail = int'(idx) >= int'(ctl.count);
  assign greater   = past_tail
                     || (bpq_pkg::class_of(val_r, ctl.bands) > ctl.new_cls);
  assign found_out = found_in | greater;
  assign at_pos    = int'(idx) == int'(ctl.pos);
  assign from_pos  = int'(idx) >= int'(ctl.pos);

  // pass the entry at the removal position down the chain
  assign carry_out = at_pos ? val_r : carry_in;
  assign val       = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.wr_en) begin
      case (ctl.kind)
        bpq_pkg::KIND_INSERT: begin
          if (found_out) begin
            val_nxt = found_in ? prev_val : ctl.value;
          end
        end
        bpq_pkg::KIND_POP,
        bpq_pkg::KIND_REMOVE: begin
          if (from_pos) begin
            val_nxt = next_val;
          end
        end
        default: begin
          val_nxt = val_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/banded_priority_queue.sv =====
// Top level of the banded priority queue: cell chain, occupancy and result register.
// Depends on bpq_pkg, bpq_cell and banded_priority_queue_macros.svh.
//
// A stable three-class priority queue of DEPTH (16) seven-bit values. Raise
// start with an operation on in_data whenever busy is low; a transfer takes
// place at that edge and one item can follow in every cycle. Exactly one
// result comes back per item, on out_data with out_valid high for a single
// cycle, from registers loaded at the transfer. The receiver cannot stall:
// capture the result in that cycle or lose it. Busy is high only while
// reset is applied and in the cycle after it. The figure of one item per
// cycle is set by the insert search, which ripples combinationally through
// the row of cells; each cell compares its own entry's class with the new
// value's. Classes come from the four band registers at the moment of use,
// so change them only while the queue is idle. Configuration writes on the
// cfg_ channel are always taken (cfg_ready is high); the two-bit index
// names exactly the four registers.
`include "banded_priority_queue_macros.svh"

module banded_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bpq_pkg::in_t                  in_data,
  output logic                          out_valid,
  output bpq_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [bpq_pkg::VAL_W-1:0]     cfg_data
);

  // band registers
  bpq_pkg::band_t bands_r;
  bpq_pkg::band_t bands_nxt;

  // occupancy and handshake state
  logic [bpq_pkg::CNT_W-1:0] count_r;
  logic [bpq_pkg::CNT_W-1:0] count_nxt;
  logic                      busy_r;
  logic                      out_valid_r;
  bpq_pkg::out_t             out_r;
  bpq_pkg::out_t             out_nxt;

  logic                      accept;
  logic                      op_ok;
  logic [bpq_pkg::POS_W-1:0] rm_pos;
  logic [bpq_pkg::VAL_W-1:0] taken;
  bpq_pkg::cell_ctl_t        ctl;

  // cell chain wiring
  logic [bpq_pkg::VAL_W-1:0] vals  [bpq_pkg::DEPTH];
  logic [bpq_pkg::VAL_W-1:0] carry [bpq_pkg::DEPTH+1];
  logic                      found [bpq_pkg::DEPTH+1];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pop always takes the head
  assign rm_pos = (in_data.kind == bpq_pkg::KIND_POP) ? '0 : in_data.position;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_comb begin
    bands_nxt = bands_r;
    if (cfg_valid) begin
      case (cfg_index)
        bpq_pkg::REG_URGENT_BELOW: bands_nxt.urgent_below = cfg_data;
        bpq_pkg::REG_URGENT_ABOVE: bands_nxt.urgent_above = cfg_data;
        bpq_pkg::REG_MIDDLE_BELOW: bands_nxt.middle_below = cfg_data;
        bpq_pkg::REG_MIDDLE_ABOVE: bands_nxt.middle_above = cfg_data;
        default: bands_nxt = bands_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decide the outcome of the item and whether the cells shift
  // ---------------------------------------------------------------------------
  always_comb begin
    op_ok     = 1'b0;
    count_nxt = count_r;
    out_nxt   = '0;
    case (in_data.kind)
      bpq_pkg::KIND_INSERT: begin
        if (int'(count_r) >= bpq_pkg::DEPTH) begin
          out_nxt.status = bpq_pkg::ST_FULL;
        end else begin
          op_ok     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bpq_pkg::KIND_POP,
      bpq_pkg::KIND_REMOVE: begin
        if (count_r == '0) begin
          out_nxt.status = bpq_pkg::ST_EMPTY;
        end else if (int'(rm_pos) >= int'(count_r)) begin
          out_nxt.status = bpq_pkg::ST_RANGE;
        end else begin
          op_ok                 = 1'b1;
          count_nxt             = count_r - 1'b1;
          out_nxt.taken_value   = taken;
          out_nxt.taken_class   = bpq_pkg::class_of(taken, bands_r);
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    out_nxt.count = count_nxt;
  end

  // broadcast to every cell
  always_comb begin
    ctl.wr_en   = accept && op_ok;
    ctl.kind    = in_data.kind;
    ctl.value   = in_data.value;
    ctl.new_cls = bpq_pkg::class_of(in_data.value, bands_r);
    ctl.pos     = rm_pos;
    ctl.count   = count_r;
    ctl.bands   = bands_r;
  end

  // ---------------------------------------------------------------------------
  // Row of cells: the insert point ripples from the head, the removed value
  // rides the carry chain, and entries shift one slot toward a neighbor
  // ---------------------------------------------------------------------------
  assign found[0] = 1'b0;
  assign carry[0] = '0;
  assign taken    = carry[bpq_pkg::DEPTH];

  for (genvar i = 0; i < bpq_pkg::DEPTH; i++) begin : g_cell
    logic [bpq_pkg::VAL_W-1:0] prev_v;
    logic [bpq_pkg::VAL_W-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = in_data.value;
    end else begin : g_body
      assign prev_v = vals[i-1];
    end

    if (i == bpq_pkg::DEPTH - 1) begin : g_tail
      assign next_v = vals[i];
    end else begin : g_inner
      assign next_v = vals[i+1];
    end

    bpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (bpq_pkg::IDX_W'(i)),
      .prev_val  (prev_v),
      .next_val  (next_v),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .val       (vals[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bands_r.urgent_below <= bpq_pkg::VAL_W'(5);
      bands_r.urgent_above <= bpq_pkg::VAL_W'(80);
      bands_r.middle_below <= bpq_pkg::VAL_W'(16);
      bands_r.middle_above <= bpq_pkg::VAL_W'(60);
      count_r              <= '0;
      busy_r               <= 1'b1;
      out_valid_r          <= 1'b0;
    end else begin
      bands_r     <= bands_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload: hold until the next transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BPQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "no result after transfer")
  `BPQ_ASSERT_IMPLY(a_count_bound, 1'b1, int'(count_r) <= bpq_pkg::DEPTH, "count overflow")
  `BPQ_ASSERT_IMPLY(a_full_count, out_valid && out_data.status == bpq_pkg::ST_FULL, int'(out_data.count) == bpq_pkg::DEPTH, "full with room")
  `BPQ_ASSERT_IMPLY(a_empty_count, out_valid && out_data.status == bpq_pkg::ST_EMPTY, out_data.count == '0, "empty with entries")

endmodule
